// File: design/ght_pkg.sv
// Package: sizes, payload structs, codes and sequencer states for the handle table.
package ght_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int BIND_W    = 97;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_LOOKUP   = 2'd1;
    localparam logic [1:0] OP_RETIRE   = 2'd2;
    localparam logic [1:0] OP_ADVANCE  = 2'd3;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_INVALID  = 3'd1;
    localparam logic [2:0] STS_DEVICE   = 3'd2;
    localparam logic [2:0] STS_BAD_DESC = 3'd3;
    localparam logic [2:0] STS_FULL     = 3'd4;
    localparam logic [2:0] STS_RETIRED  = 3'd5;
    localparam logic [2:0] STS_NONE_REL = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_RETIRE_FRAMES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID     = 1'd1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        id_valid;
        logic [7:0]  slot_index;
        logic [31:0] generation;
        logic        view_valid;
        logic [31:0] view_handle;
        logic [31:0] view_device;
        logic [15:0] width;
        logic [15:0] height;
        logic        alpha_mode;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_slot_index;
        logic [31:0] out_generation;
        logic [31:0] out_view_handle;
        logic [31:0] out_view_device;
        logic [15:0] out_width;
        logic [15:0] out_height;
        logic        out_alpha_mode;
        logic [6:0]  live_count;
        logic [6:0]  retired_count;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [31:0] view;
        logic [31:0] dev;
        logic [15:0] w;
        logic [15:0] h;
        logic        alpha;
    } t_bind;

    // Aging unit result for one slot.
    typedef struct packed {
        logic       release_now;
        logic [7:0] age;
    } t_age_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SWEEP,
        S_EMIT,
        S_OUT,
        S_OUT_REL
    } t_state;

endpackage

// File: design/ght_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: design/ght_age_unit.sv
// Shared aging unit: saturating age bump and release compare for one slot.
module ght_age_unit import ght_pkg::*; (
    input  logic       i_alive,
    input  logic       i_retired,
    input  logic [7:0] i_age,
    input  logic [7:0] i_retire_frames,
    output t_age_res   o_res
);

    logic [7:0] aged;

    assign aged = (i_age == 8'hFF) ? i_age : i_age + 8'd1;

    always_comb begin
        o_res.release_now = 1'b0;
        o_res.age         = i_age;
        if (i_alive && i_retired) begin
            o_res.age         = aged;
            o_res.release_now = (aged >= i_retire_frames);
        end
    end

endmodule

// File: design/generational_handle_table.sv
// Generational handle table: slot state, free stack, sequencer and result register.
// Register, lookup, retire: input registered, checked in S_CHECK, result registered into S_OUT
//   and held until taken; the next transaction is accepted once the result is taken.
// Advance frame: check, then an aging sweep of every slot, one slot a cycle, then either a
//   none-released result or a scan (S_EMIT) of released slots, each result held until taken.
// One transaction in flight; the input is stalled until the last result is taken.
// Synchronous active-low reset clears all slot flags, ages, generations and counts.
module generational_handle_table import ght_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out
);

    // configuration
    logic [7:0]  r_retire_frames;
    logic [31:0] r_device_id;

    // per-slot state in flops
    logic [31:0] r_gen     [MAX_SLOTS];
    logic        r_alive   [MAX_SLOTS];
    logic        r_retired [MAX_SLOTS];
    logic [7:0]  r_age     [MAX_SLOTS];
    logic [IDX_W-1:0] r_fstack [MAX_SLOTS];
    logic [CNT_W-1:0] r_fdepth;
    logic [CNT_W-1:0] r_used;
    logic [CNT_W-1:0] r_live;
    logic [CNT_W-1:0] r_ret;

    // sequencer
    t_state r_state, n_state;
    t_in    r_in;
    t_out   r_out, n_out;
    logic [IDX_W-1:0] r_k;
    logic [CNT_W-1:0] r_nrel;
    logic [MAX_SLOTS-1:0] r_mask;

    logic in_acc, out_acc;
    logic k_last;

    // binding memory
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    t_bind            ram_wdata, ram_rdata;

    // aging unit on slot r_k
    t_age_res age_res;

    // register decode
    logic [IDX_W-1:0] reg_idx;
    logic [2:0]       reg_sts;
    logic             reg_pop;
    // handle decode
    logic [IDX_W-1:0] h_idx;
    logic [2:0]       h_sts;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;
    assign k_last  = (r_k == IDX_W'(MAX_SLOTS - 1));
    assign o_out   = r_out;

    ght_ram #(.WIDTH(BIND_W), .DEPTH(MAX_SLOTS)) u_bind_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    ght_age_unit u_age (
        .i_alive        (r_alive[r_k]),
        .i_retired      (r_retired[r_k]),
        .i_age          (r_age[r_k]),
        .i_retire_frames(r_retire_frames),
        .o_res          (age_res)
    );

    // Register: descriptor checks, then LIFO reuse, fresh append or full.
    always_comb begin
        reg_sts = STS_OK;
        reg_pop = 1'b0;
        reg_idx = r_used[IDX_W-1:0];
        if (!r_in.view_valid) begin
            reg_sts = STS_INVALID;
        end else if (r_in.view_device != r_device_id) begin
            reg_sts = STS_DEVICE;
        end else if (r_in.width == 16'd0 || r_in.height == 16'd0) begin
            reg_sts = STS_BAD_DESC;
        end else if (r_fdepth != '0) begin
            reg_pop = 1'b1;
            reg_idx = r_fstack[r_fdepth[IDX_W-1:0] - IDX_W'(1)];
        end else if (r_used == CNT_W'(MAX_SLOTS)) begin
            reg_sts = STS_FULL;
        end
    end

    // Lookup / retire: handle checks in order; device from the bound entry.
    always_comb begin
        h_idx = r_in.slot_index[IDX_W-1:0];
        h_sts = STS_OK;
        if (!r_in.id_valid) begin
            h_sts = STS_INVALID;
        end else if (9'(r_in.slot_index) >= 9'(r_used)) begin
            h_sts = STS_INVALID;
        end else if (!r_alive[h_idx] || r_gen[h_idx] != r_in.generation) begin
            h_sts = STS_INVALID;
        end else if (r_retired[h_idx]) begin
            h_sts = STS_RETIRED;
        end else if (ram_rdata.dev != r_device_id) begin
            h_sts = STS_DEVICE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = (r_in.opcode == OP_ADVANCE) ? S_SWEEP : S_OUT;
            end
            S_SWEEP: begin
                if (k_last) begin
                    n_state = (r_nrel == '0 && !age_res.release_now) ? S_OUT : S_EMIT;
                end
            end
            S_EMIT: begin
                if (r_mask[r_k]) begin
                    n_state = S_OUT_REL;
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    n_state = S_IDLE;
                end
            end
            S_OUT_REL: begin
                if (out_acc) begin
                    n_state = r_out.last ? S_IDLE : S_EMIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = (r_state == S_OUT) || (r_state == S_OUT_REL);
        ram_raddr   = i_in.slot_index[IDX_W-1:0];
        ram_waddr   = reg_idx;
        ram_we      = (r_state == S_CHECK) && (r_in.opcode == OP_REGISTER)
                      && (reg_sts == STS_OK);
        ram_wdata.view  = r_in.view_handle;
        ram_wdata.dev   = r_in.view_device;
        ram_wdata.w     = r_in.width;
        ram_wdata.h     = r_in.height;
        ram_wdata.alpha = r_in.alpha_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retire_frames <= 8'd2;
            r_device_id     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RETIRE_FRAMES: r_retire_frames <= i_cfg_data[7:0];
                CFG_DEVICE_ID:     r_device_id     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // result register next value; held otherwise
    always_comb begin
        n_out = r_out;
        if (r_state == S_CHECK && r_in.opcode != OP_ADVANCE) begin
            n_out               = '0;
            n_out.last          = 1'b1;
            n_out.live_count    = 7'(r_live);
            n_out.retired_count = 7'(r_ret);
            if (r_in.opcode == OP_REGISTER) begin
                n_out.status = reg_sts;
                if (reg_sts == STS_OK) begin
                    n_out.out_slot_index = 8'(reg_idx);
                    n_out.out_generation = reg_pop ? r_gen[reg_idx] + 32'd1 : 32'd1;
                    n_out.live_count     = 7'(r_live + CNT_W'(1));
                end
            end else begin
                n_out.status = h_sts;
                if (h_sts == STS_OK && r_in.opcode == OP_LOOKUP) begin
                    n_out.out_view_handle = ram_rdata.view;
                    n_out.out_view_device = ram_rdata.dev;
                    n_out.out_width       = ram_rdata.w;
                    n_out.out_height      = ram_rdata.h;
                    n_out.out_alpha_mode  = ram_rdata.alpha;
                end
                if (h_sts == STS_OK && r_in.opcode == OP_RETIRE) begin
                    n_out.live_count    = 7'(r_live - CNT_W'(1));
                    n_out.retired_count = 7'(r_ret + CNT_W'(1));
                end
            end
        end else if (r_state == S_SWEEP && k_last && n_state == S_OUT) begin
            n_out               = '0;
            n_out.status        = STS_NONE_REL;
            n_out.live_count    = 7'(r_live);
            n_out.retired_count = 7'(r_ret);
            n_out.last          = 1'b1;
        end else if (r_state == S_EMIT && r_mask[r_k]) begin
            n_out                = '0;
            n_out.status         = STS_OK;
            n_out.out_slot_index = 8'(r_k);
            n_out.out_generation = r_gen[r_k];
            n_out.live_count     = 7'(r_live);
            n_out.retired_count  = 7'(r_ret);
            n_out.last           = (r_nrel == CNT_W'(1));
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
        r_out <= n_out;
    end

    // slot state, free stack, counts, scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_gen[i]     <= '0;
                r_alive[i]   <= 1'b0;
                r_retired[i] <= 1'b0;
                r_age[i]     <= '0;
            end
            r_fdepth <= '0;
            r_used   <= '0;
            r_live   <= '0;
            r_ret    <= '0;
            r_k      <= '0;
            r_nrel   <= '0;
            r_mask   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_k    <= '0;
                    r_nrel <= '0;
                    r_mask <= '0;
                end
                S_CHECK: begin
                    if (r_in.opcode == OP_REGISTER && reg_sts == STS_OK) begin
                        r_gen[reg_idx]     <= reg_pop ? r_gen[reg_idx] + 32'd1 : 32'd1;
                        r_alive[reg_idx]   <= 1'b1;
                        r_retired[reg_idx] <= 1'b0;
                        r_age[reg_idx]     <= '0;
                        r_live             <= r_live + CNT_W'(1);
                        if (reg_pop) begin
                            r_fdepth <= r_fdepth - CNT_W'(1);
                        end else begin
                            r_used <= r_used + CNT_W'(1);
                        end
                    end
                    if (r_in.opcode == OP_RETIRE && h_sts == STS_OK) begin
                        r_retired[h_idx] <= 1'b1;
                        r_age[h_idx]     <= '0;
                        r_live           <= r_live - CNT_W'(1);
                        r_ret            <= r_ret + CNT_W'(1);
                    end
                end
                S_SWEEP: begin
                    // one slot a cycle: age, and free on reaching the threshold
                    if (age_res.release_now) begin
                        r_alive[r_k]   <= 1'b0;
                        r_retired[r_k] <= 1'b0;
                        r_age[r_k]     <= '0;
                        r_mask[r_k]    <= 1'b1;
                        r_nrel         <= r_nrel + CNT_W'(1);
                        r_ret          <= r_ret - CNT_W'(1);
                        if (r_fdepth < CNT_W'(MAX_SLOTS)) begin
                            r_fstack[r_fdepth[IDX_W-1:0]] <= r_k;
                            r_fdepth <= r_fdepth + CNT_W'(1);
                        end
                    end else begin
                        r_age[r_k] <= age_res.age;
                    end
                    r_k <= k_last ? '0 : r_k + IDX_W'(1);
                end
                S_EMIT: begin
                    if (r_mask[r_k]) begin
                        r_nrel <= r_nrel - CNT_W'(1);
                    end else begin
                        r_k <= r_k + IDX_W'(1);
                    end
                end
                S_OUT_REL: begin
                    if (out_acc) begin
                        r_k <= r_k + IDX_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: tb/tb.sv
// Testbench for the generational handle table: directed table plus random traffic.
`timescale 1ns / 1ps

module tb;
    import ght_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in                  i_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out                 o_out;

    generational_handle_table i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Directed row: stimulus plus an optional typed status.
    typedef struct {
        t_in        item;
        logic       chk;
        logic [2:0] sts;
    } t_dir_row;

    // Shadow copy of the table state
    logic [7:0]  m_ret_frames;
    logic [31:0] m_dev_id;
    logic [31:0] m_gen   [MAX_SLOTS];
    logic        m_alive [MAX_SLOTS];
    logic        m_ret   [MAX_SLOTS];
    logic [7:0]  m_age   [MAX_SLOTS];
    t_bind       m_bind  [MAX_SLOTS];
    int          m_free  [MAX_SLOTS];  // freed slots, LIFO, top at m_fdepth - 1
    int          m_fdepth;
    int          m_used;

    t_out exp_results[$];
    int   err_cnt;
    int   seen_in;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        err_cnt++;
        $display("mismatch %s: got %0h expected %0h (%0t)", what, got, want, $time);
    endtask

    task automatic queue_result(input t_out x);
        exp_results = {exp_results, x};
    endtask

    function automatic logic [2:0] handle_status(input t_in it);
        int s;
        s = int'(it.slot_index);
        if (!it.id_valid) return STS_INVALID;
        if (s >= m_used) return STS_INVALID;
        if (!m_alive[s] || m_gen[s] != it.generation) return STS_INVALID;
        if (m_ret[s]) return STS_RETIRED;
        if (m_bind[s].dev != m_dev_id) return STS_DEVICE;
        return STS_OK;
    endfunction

    // Computes the results of one transaction and queues them.
    task automatic predict_table(input t_in it);
        t_out r;
        t_out rel[MAX_SLOTS];
        int   nrel;
        int   idx, live, retc;
        idx  = 0;
        nrel = 0;
        r    = '0;
        case (it.opcode)
            OP_REGISTER: begin
                if (!it.view_valid) r.status = STS_INVALID;
                else if (it.view_device != m_dev_id) r.status = STS_DEVICE;
                else if (it.width == 0 || it.height == 0) r.status = STS_BAD_DESC;
                else begin
                    if (m_fdepth > 0) begin
                        m_fdepth--;
                        idx = m_free[m_fdepth];
                        m_gen[idx] = m_gen[idx] + 32'd1;
                    end else if (m_used >= MAX_SLOTS) begin
                        r.status = STS_FULL;
                    end else begin
                        idx = m_used++;
                        m_gen[idx] = 32'd1;
                    end
                    if (r.status == STS_OK) begin
                        m_alive[idx] = 1'b1;
                        m_ret[idx]   = 1'b0;
                        m_age[idx]   = '0;
                        m_bind[idx]  = '{it.view_handle, it.view_device, it.width,
                                         it.height, it.alpha_mode};
                        r.out_slot_index = 8'(idx);
                        r.out_generation = m_gen[idx];
                    end
                end
            end
            OP_LOOKUP, OP_RETIRE: begin
                r.status = handle_status(it);
                if (r.status == STS_OK) begin
                    idx = int'(it.slot_index);
                    if (it.opcode == OP_LOOKUP) begin
                        r.out_view_handle = m_bind[idx].view;
                        r.out_view_device = m_bind[idx].dev;
                        r.out_width       = m_bind[idx].w;
                        r.out_height      = m_bind[idx].h;
                        r.out_alpha_mode  = m_bind[idx].alpha;
                    end else begin
                        m_ret[idx] = 1'b1;
                        m_age[idx] = '0;
                    end
                end
            end
            default: begin
                for (int k = 0; k < m_used; k++) begin
                    if (!m_alive[k] || !m_ret[k]) continue;
                    if (m_age[k] != 8'hff) m_age[k]++;
                    if (m_age[k] < m_ret_frames) continue;
                    rel[nrel] = '0;
                    rel[nrel].out_slot_index = 8'(k);
                    rel[nrel].out_generation = m_gen[k];
                    nrel++;
                    m_alive[k] = 1'b0;
                    m_ret[k]   = 1'b0;
                    m_age[k]   = '0;
                    m_bind[k]  = '0;
                    if (m_fdepth < MAX_SLOTS) begin
                        m_free[m_fdepth] = k;
                        m_fdepth++;
                    end
                end
                if (nrel == 0) r.status = STS_NONE_REL;
            end
        endcase
        live = 0;
        retc = 0;
        for (int k = 0; k < m_used; k++)
            if (m_alive[k]) begin
                if (m_ret[k]) retc++;
                else live++;
            end
        if (nrel == 0) begin
            rel[0] = r;
            nrel   = 1;
        end
        for (int k = 0; k < nrel; k++) begin
            rel[k].live_count    = 7'(live);
            rel[k].retired_count = 7'(retc);
            rel[k].last          = (k == nrel - 1);
            queue_result(rel[k]);
        end
    endtask

    // Result side: random stall per result, field-wise compare.
    initial begin
        int hold;
        t_out e;
        i_out_stall = 1'b1;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if (exp_results.size() == 0) begin
                    report("unexpected result", 64'(o_out.status), 64'd0);
                end else begin
                    e = exp_results.pop_front();
                    if (o_out.status !== e.status)
                        report("status", 64'(o_out.status), 64'(e.status));
                    if (o_out.out_slot_index !== e.out_slot_index)
                        report("slot", 64'(o_out.out_slot_index), 64'(e.out_slot_index));
                    if (o_out.out_generation !== e.out_generation)
                        report("generation", 64'(o_out.out_generation),
                               64'(e.out_generation));
                    if (o_out.out_view_handle !== e.out_view_handle)
                        report("view", 64'(o_out.out_view_handle), 64'(e.out_view_handle));
                    if (o_out.out_view_device !== e.out_view_device)
                        report("device", 64'(o_out.out_view_device), 64'(e.out_view_device));
                    if (o_out.out_width !== e.out_width)
                        report("width", 64'(o_out.out_width), 64'(e.out_width));
                    if (o_out.out_height !== e.out_height)
                        report("height", 64'(o_out.out_height), 64'(e.out_height));
                    if (o_out.out_alpha_mode !== e.out_alpha_mode)
                        report("alpha", 64'(o_out.out_alpha_mode), 64'(e.out_alpha_mode));
                    if (o_out.live_count !== e.live_count)
                        report("live", 64'(o_out.live_count), 64'(e.live_count));
                    if (o_out.retired_count !== e.retired_count)
                        report("retired", 64'(o_out.retired_count), 64'(e.retired_count));
                    if (o_out.last !== e.last) report("last", 64'(o_out.last), 64'(e.last));
                end
                // new stall draw for the next result; quiet stretches some of the time
                hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end
            if (!i_rst_n) i_out_stall <= 1'b1;
            else if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else i_out_stall <= 1'b0;
        end
    end

    // Drives one transaction: random gap, then holds valid until accepted.
    task automatic send_item(input t_in it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_table(it);
        seen_in++;
    endtask

    // Directed row: a typed status replaces the predicted one.
    task automatic send_row(input t_dir_row row);
        send_item(row.item);
        if (row.chk) exp_results[exp_results.size() - 1].status = row.sts;
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RETIRE_FRAMES) m_ret_frames = val[7:0];
        else m_dev_id = val;
        @(posedge i_clk);
    endtask

    // Waits for the pipeline to drain: every queued result has been taken.
    task automatic drain_table;
        i_in_valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (3 * MAX_SLOTS + 8) @(posedge i_clk);
    endtask

    function automatic t_in mk_reg(input logic vv, input logic [31:0] dev,
                                   input logic [15:0] w, input logic [15:0] h);
        t_in it;
        it = '0;
        it.opcode      = OP_REGISTER;
        it.view_valid  = vv;
        it.view_handle = $urandom();
        it.view_device = dev;
        it.width       = w;
        it.height      = h;
        it.alpha_mode  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_in mk_handle(input logic [1:0] op, input logic idv,
                                      input logic [7:0] s, input logic [31:0] g);
        t_in it;
        it = '0;
        it.view_valid  = 1'($urandom_range(0, 1));
        it.width       = 16'($urandom());
        it.height      = 16'($urandom());
        it.alpha_mode  = 1'($urandom_range(0, 1));
        it.view_handle = $urandom();
        it.view_device = $urandom();
        it.generation  = g;
        it.slot_index  = s;
        it.id_valid    = idv;
        it.opcode      = op;
        return it;
    endfunction

    function automatic t_dir_row mk_row(input t_in it, input logic chk, input logic [2:0] sts);
        t_dir_row row;
        row.item = it;
        row.chk  = chk;
        row.sts  = sts;
        return row;
    endfunction

    // Handle of a live-ish slot with its current generation, or a noisy one.
    function automatic t_in rand_handle(input logic [1:0] op);
        int s;
        logic [31:0] g;
        s = (m_used > 0) ? $urandom_range(0, m_used - 1) : 0;
        g = m_gen[s];
        case ($urandom_range(0, 9))
            0: return mk_handle(op, 1'b0, 8'(s), g);
            1: return mk_handle(op, 1'b1, 8'($urandom_range(0, 255)), $urandom());
            2: return mk_handle(op, 1'b1, 8'(s), g ^ (32'h1 << $urandom_range(0, 31)));
            default: return mk_handle(op, 1'b1, 8'(s), g);
        endcase
    endfunction

    t_dir_row dir_tab[$];

    initial begin
        t_in it;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in       = '0;
        err_cnt    = 0;
        seen_in    = 0;
        m_ret_frames = 8'd2;
        m_dev_id     = '0;
        m_used       = 0;
        m_fdepth     = 0;
        for (int k = 0; k < MAX_SLOTS; k++) begin
            m_gen[k] = '0; m_alive[k] = 1'b0; m_ret[k] = 1'b0;
            m_age[k] = '0; m_bind[k] = '0; m_free[k] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at reset config: descriptor errors, a lookup and an advance on the empty table,
        // extremes of field values, retire and release after two frames.
        dir_tab = {dir_tab, mk_row(mk_handle(OP_LOOKUP, 1'b1, 8'd0, 32'd0), 1'b1, STS_INVALID)};
        dir_tab = {dir_tab, mk_row(mk_handle(OP_ADVANCE, 1'b0, 8'd0, 32'd0),
                                   1'b1, STS_NONE_REL)};
        dir_tab = {dir_tab, mk_row(mk_reg(1'b0, 32'd0, 16'd1, 16'd1), 1'b1, STS_INVALID)};
        dir_tab = {dir_tab, mk_row(mk_reg(1'b1, 32'hffff_ffff, 16'd1, 16'd1), 1'b1, STS_DEVICE)};
        dir_tab = {dir_tab, mk_row(mk_reg(1'b1, 32'd0, 16'd0, 16'd5), 1'b1, STS_BAD_DESC)};
        dir_tab = {dir_tab, mk_row(mk_reg(1'b1, 32'd0, 16'd5, 16'd0), 1'b1, STS_BAD_DESC)};
        dir_tab = {dir_tab, mk_row(mk_reg(1'b1, 32'd0, 16'hffff, 16'hffff), 1'b0, STS_OK)};
        dir_tab = {dir_tab, mk_row(mk_reg(1'b1, 32'd0, 16'd1, 16'd1), 1'b0, STS_OK)};
        dir_tab = {dir_tab, mk_row(mk_handle(OP_LOOKUP, 1'b1, 8'd0, 32'd1), 1'b0, STS_OK)};
        dir_tab = {dir_tab, mk_row(mk_handle(OP_LOOKUP, 1'b0, 8'd0, 32'd1), 1'b1, STS_INVALID)};
        dir_tab = {dir_tab, mk_row(mk_handle(OP_LOOKUP, 1'b1, 8'd255, 32'hffff_ffff),
                                   1'b1, STS_INVALID)};
        dir_tab = {dir_tab, mk_row(mk_handle(OP_RETIRE, 1'b1, 8'd1, 32'd1), 1'b0, STS_OK)};
        dir_tab = {dir_tab, mk_row(mk_handle(OP_LOOKUP, 1'b1, 8'd1, 32'd1), 1'b1, STS_RETIRED)};
        dir_tab = {dir_tab, mk_row(mk_handle(OP_RETIRE, 1'b1, 8'd1, 32'd1), 1'b1, STS_RETIRED)};
        dir_tab = {dir_tab, mk_row(mk_handle(OP_ADVANCE, 1'b0, 8'd0, 32'd0), 1'b0, STS_OK)};
        dir_tab = {dir_tab, mk_row(mk_handle(OP_ADVANCE, 1'b0, 8'd0, 32'd0), 1'b0, STS_OK)};
        dir_tab = {dir_tab, mk_row(mk_reg(1'b1, 32'd0, 16'd3, 16'd4), 1'b0, STS_OK)};
        dir_tab = {dir_tab, mk_row(mk_handle(OP_LOOKUP, 1'b1, 8'd1, 32'd2), 1'b0, STS_OK)};
        foreach (dir_tab[k]) send_row(dir_tab[k]);
        drain_table();

        // Fill up to full, device mismatch after a device change, zero retirement.
        write_cfg(CFG_DEVICE_ID, 32'hffff_ffff);
        write_cfg(CFG_RETIRE_FRAMES, 32'd0);
        send_item(rand_handle(OP_LOOKUP));
        for (int k = 0; k < MAX_SLOTS + 1; k++)
            send_item(mk_reg(1'b1, 32'hffff_ffff, 16'($urandom()), 16'hffff));
        for (int k = 0; k < MAX_SLOTS; k++) send_item(rand_handle(OP_RETIRE));
        send_item(mk_handle(OP_ADVANCE, 1'b0, 8'd0, 32'd0));
        drain_table();

        // Random phases over several settings, including max retirement.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_cfg(CFG_RETIRE_FRAMES, 32'd1);
                2: write_cfg(CFG_RETIRE_FRAMES, 32'd255);
                3: write_cfg(CFG_RETIRE_FRAMES, 32'd3);
                4: write_cfg(CFG_DEVICE_ID, 32'd0);
                5: write_cfg(CFG_DEVICE_ID, $urandom());
                default: write_cfg(CFG_DEVICE_ID, 32'h5a5a_0001);
            endcase
            for (int n = 0; n < 50; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        if ($urandom_range(0, 7) == 0)
                            it = mk_reg(1'($urandom_range(0, 1)), $urandom(),
                                        16'($urandom_range(0, 2)), 16'($urandom()));
                        else
                            it = mk_reg(1'b1, m_dev_id, 16'($urandom_range(1, 65535)),
                                        16'($urandom_range(1, 65535)));
                    end
                    3, 4:    it = rand_handle(OP_LOOKUP);
                    5, 6:    it = rand_handle(OP_RETIRE);
                    default: it = mk_handle(OP_ADVANCE, 1'($urandom_range(0, 1)),
                                            8'($urandom()), $urandom());
                endcase
                send_item(it);
            end
            drain_table();
        end

        if (err_cnt == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #10000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
